[design/tba_pkg.sv]
// tba_pkg: shared types, codes and sizes for the token bucket allocator
// used by tba_div and token_bucket_allocator; no dependencies
package tba_pkg;

    // table sizes
    localparam int BUCKETS = 8;
    localparam int AGENTS  = 16;
    localparam int SLOTS   = 32;

    localparam int BW = $clog2(BUCKETS);
    localparam int AW = $clog2(AGENTS);
    localparam int SW = $clog2(SLOTS);
    localparam int UW = AW + BW;

    localparam logic [BW-1:0] BUCKET_LAST = BW'(BUCKETS - 1);
    localparam logic [SW-1:0] SLOT_LAST   = SW'(SLOTS - 1);

    // register reset values and usage saturation limit
    localparam logic [15:0] MAX_TOKENS_RST = 16'd100;
    localparam logic [15:0] RATE_RST       = 16'd10;
    localparam logic [15:0] BURST_RST      = 16'd50;
    localparam logic [15:0] INTERVAL_RST   = 16'd1000;
    localparam logic [20:0] USAGE_MAX      = 21'h1FFFFF;

    typedef enum logic [2:0] {
        CFG_MAX_TOKENS   = 3'd0,
        CFG_REFILL_RATE  = 3'd1,
        CFG_BURST_SIZE   = 3'd2,
        CFG_INTERVAL     = 3'd3,
        CFG_QUOTA_ENABLE = 3'd4,
        CFG_QUOTA_LIMIT  = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_REQUEST    = 2'd0,
        OP_RELEASE    = 2'd1,
        OP_REFILL_ALL = 2'd2,
        OP_EXPIRE     = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        STS_OK         = 3'd0,
        STS_QUOTA      = 3'd1,
        STS_NO_TOKENS  = 3'd2,
        STS_TABLE_FULL = 3'd3,
        STS_BAD_HANDLE = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_REQ_QCHK,
        ST_RF_CHK,
        ST_RF_DIV,
        ST_RF_MUL,
        ST_RF_ADD,
        ST_RF_NEXT,
        ST_REQ_SCAN,
        ST_REQ_DONE,
        ST_FREE_RD,
        ST_FREE_WAIT,
        ST_FREE_WR,
        ST_SW_CHK,
        ST_FIN_RD,
        ST_FIN_WAIT,
        ST_FIN_OUT,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic [AW-1:0] agent;
        logic [BW-1:0] bucket;
        logic [15:0]   tokens;
        logic [31:0]   expiry;
    } t_slot;

endpackage

[design/tba_div.sv]
// tba_div: iterative 32 by 16 bit unsigned divider, one quotient bit per cycle
// depends on tba_pkg only by convention; no submodules
module tba_div
    import tba_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);

    logic [15:0] r_rem;
    logic [31:0] r_quo;
    logic [15:0] r_div;
    logic [5:0]  r_cnt;
    logic        r_done;
    logic [16:0] shifted;
    logic        ge;

    // one restoring step
    assign shifted = {r_rem, r_quo[31]};
    assign ge      = shifted >= {1'b0, r_div};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == 6'd1);
            if (i_start) begin
                r_cnt <= 6'd32;
            end else if (r_cnt != 6'd0) begin
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    // datapath, the remainder always fits below a nonzero divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_cnt != 6'd0) begin
            r_rem <= 16'(ge ? (shifted - {1'b0, r_div}) : shifted);
            r_quo <= {r_quo[30:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[design/token_bucket_allocator.sv]
// token_bucket_allocator: token buckets, allocation slot table, per agent usage
// depends on tba_pkg and tba_div (shared refill divider)
//
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_stall  | opcode, now_time, bucket, agent, count, hold, handle
//  result  | out       | o_valid / i_stall  | status, handle, granted, available, usage, expired
//  config  | in        | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// one item at a time; a refill runs the bit-serial divider unless no interval has passed
// request: a refill plus a slot scan, cut short when over quota
// release: frees the slot, cut short for a bad handle; refill all: 8 refills in turn
// expire sweep: checks every slot and frees each expired one; synchronous reset clears state
// a result waiting in the output register does not block the next beat from being taken
module token_bucket_allocator
    import tba_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_now_time,
    input  logic [2:0]  i_bucket_index,
    input  logic [3:0]  i_agent_index,
    input  logic [15:0] i_token_count,
    input  logic [23:0] i_hold_time,
    input  logic [4:0]  i_handle,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [4:0]  o_granted_handle,
    output logic [15:0] o_tokens_granted,
    output logic [15:0] o_tokens_available,
    output logic [20:0] o_agent_usage_now,
    output logic [5:0]  o_expired_count,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [20:0] i_cfg_data
);

    t_state r_state, n_state;

    // configuration
    logic [15:0] r_max, r_rate, r_burst, r_intv;
    logic        r_qen;
    logic [20:0] r_qlim;

    // bucket and slot state
    logic [15:0] r_level [BUCKETS];
    logic [31:0] r_last  [BUCKETS];
    logic [SLOTS-1:0] r_slot_vld;
    t_slot       r_slot  [SLOTS];

    // usage memory with per entry valid bits
    logic [20:0] r_umem [AGENTS*BUCKETS];
    logic [AGENTS*BUCKETS-1:0] r_uent_vld;
    logic [20:0] r_udata;
    logic        r_uvld;
    logic [UW-1:0] r_uaddr;

    // latched beat
    t_op         r_op;
    logic [31:0] r_now;
    logic [BW-1:0] r_b;
    logic [AW-1:0] r_a;
    logic [15:0] r_tok;
    logic [23:0] r_hold;
    logic [SW-1:0] r_h;

    // sequencer registers
    logic [BW-1:0] r_bidx;
    logic [SW-1:0] r_sidx;
    logic        r_found;
    logic [20:0] r_usage;
    logic [47:0] r_prod;
    logic [5:0]  r_exp;

    // staged result and output register
    logic [2:0]  r_st;
    logic [4:0]  r_gh;
    logic [15:0] r_tg, r_av;
    logic [20:0] r_us;
    logic        r_ovalid;
    logic [2:0]  r_o_st;
    logic [4:0]  r_o_gh;
    logic [15:0] r_o_tg, r_o_av;
    logic [20:0] r_o_us;
    logic [5:0]  r_o_exp;

    // combinational datapath
    logic        accept;
    logic [15:0] lvl_cur;
    logic [31:0] last_cur;
    t_slot       slot_cur;
    logic [20:0] u_cur;
    logic [31:0] elapsed;
    logic [15:0] iv;
    logic        rf_skip;
    logic        div_start, div_done;
    logic [31:0] div_quo;
    logic [15:0] rf_add;
    logic [16:0] rf_sum;
    logic [15:0] rf_lvl;
    logic        quota_fail;
    logic [21:0] grant_sum;
    logic [20:0] grant_usage;
    logic        no_tokens;
    logic [16:0] free_sum;
    logic [15:0] free_lvl;
    logic [20:0] free_usage;
    logic [31:0] exp_diff;
    logic        expired;
    logic        res_load;

    assign accept   = i_valid && !o_stall;
    assign lvl_cur  = r_level[r_bidx];
    assign last_cur = r_last[r_bidx];
    assign slot_cur = r_slot[r_sidx];
    assign u_cur    = r_uvld ? r_udata : '0;

    // refill arithmetic
    assign elapsed   = r_now - last_cur;
    assign iv        = (r_intv == 16'd0) ? 16'd1 : r_intv;
    assign rf_skip   = elapsed < {16'd0, iv};
    assign div_start = (r_state == ST_RF_CHK) && !rf_skip;
    assign rf_add    = (r_prod > {32'd0, r_burst}) ? r_burst : r_prod[15:0];
    assign rf_sum    = {1'b0, lvl_cur} + {1'b0, rf_add};
    assign rf_lvl    = (rf_sum > {1'b0, r_max}) ? r_max : rf_sum[15:0];

    // request arithmetic
    assign quota_fail  = r_qen && (({1'b0, u_cur} + {6'd0, r_tok}) > {1'b0, r_qlim});
    assign grant_sum   = {1'b0, r_usage} + {6'd0, r_tok};
    assign grant_usage = grant_sum[21] ? USAGE_MAX : grant_sum[20:0];
    assign no_tokens   = lvl_cur < r_tok;

    // release arithmetic
    assign free_sum   = {1'b0, lvl_cur} + {1'b0, slot_cur.tokens};
    assign free_lvl   = (free_sum > {1'b0, r_max}) ? r_max : free_sum[15:0];
    assign free_usage = (u_cur > {5'd0, slot_cur.tokens}) ?
                        (u_cur - {5'd0, slot_cur.tokens}) : '0;

    // expiry test
    assign exp_diff = r_now - slot_cur.expiry;
    assign expired  = r_slot_vld[r_sidx] && (exp_diff != 32'd0) && !exp_diff[31];

    assign res_load = (r_state == ST_RESULT) && (!r_ovalid || !i_stall);

    tba_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (elapsed),
        .i_divisor  (iv),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                unique case (r_op)
                    OP_REQUEST:    n_state = ST_REQ_QCHK;
                    OP_RELEASE:    n_state = r_slot_vld[r_h] ? ST_FREE_RD : ST_RESULT;
                    OP_REFILL_ALL: n_state = ST_RF_CHK;
                    OP_EXPIRE:     n_state = ST_SW_CHK;
                    default:       n_state = ST_IDLE;
                endcase
            end
            ST_REQ_QCHK:  n_state = quota_fail ? ST_RESULT : ST_RF_CHK;
            ST_RF_CHK:    n_state = rf_skip ? ST_RF_NEXT : ST_RF_DIV;
            ST_RF_DIV: begin
                if (div_done) n_state = ST_RF_MUL;
            end
            ST_RF_MUL:    n_state = ST_RF_ADD;
            ST_RF_ADD:    n_state = ST_RF_NEXT;
            ST_RF_NEXT: begin
                if (r_op == OP_REQUEST) begin
                    n_state = ST_REQ_SCAN;
                end else if (r_bidx == BUCKET_LAST) begin
                    n_state = ST_FIN_RD;
                end else begin
                    n_state = ST_RF_CHK;
                end
            end
            ST_REQ_SCAN: begin
                if (!r_slot_vld[r_sidx] || r_sidx == SLOT_LAST) n_state = ST_REQ_DONE;
            end
            ST_REQ_DONE:  n_state = ST_RESULT;
            ST_FREE_RD:   n_state = ST_FREE_WAIT;
            ST_FREE_WAIT: n_state = ST_FREE_WR;
            ST_FREE_WR: begin
                if (r_op == OP_RELEASE) begin
                    n_state = ST_RESULT;
                end else if (r_sidx == SLOT_LAST) begin
                    n_state = ST_FIN_RD;
                end else begin
                    n_state = ST_SW_CHK;
                end
            end
            ST_SW_CHK: begin
                if (expired) begin
                    n_state = ST_FREE_RD;
                end else if (r_sidx == SLOT_LAST) begin
                    n_state = ST_FIN_RD;
                end
            end
            ST_FIN_RD:    n_state = ST_FIN_WAIT;
            ST_FIN_WAIT:  n_state = ST_FIN_OUT;
            ST_FIN_OUT:   n_state = ST_RESULT;
            ST_RESULT: begin
                if (res_load) n_state = ST_IDLE;
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    // configuration, bucket state, valid bits and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max      <= MAX_TOKENS_RST;
            r_rate     <= RATE_RST;
            r_burst    <= BURST_RST;
            r_intv     <= INTERVAL_RST;
            r_qen      <= 1'b0;
            r_qlim     <= '0;
            r_slot_vld <= '0;
            r_uent_vld <= '0;
            r_ovalid   <= 1'b0;
            for (int i = 0; i < BUCKETS; i++) begin
                r_level[i] <= MAX_TOKENS_RST;
                r_last[i]  <= '0;
            end
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_MAX_TOKENS:   r_max   <= i_cfg_data[15:0];
                    CFG_REFILL_RATE:  r_rate  <= i_cfg_data[15:0];
                    CFG_BURST_SIZE:   r_burst <= i_cfg_data[15:0];
                    CFG_INTERVAL:     r_intv  <= i_cfg_data[15:0];
                    CFG_QUOTA_ENABLE: r_qen   <= i_cfg_data[0];
                    CFG_QUOTA_LIMIT:  r_qlim  <= i_cfg_data;
                    default: ;
                endcase
            end
            // bucket refill
            if (r_state == ST_RF_ADD) begin
                r_level[r_bidx] <= rf_lvl;
                r_last[r_bidx]  <= r_now;
            end
            // grant
            if (r_state == ST_REQ_DONE && !no_tokens && r_found) begin
                r_level[r_bidx]    <= lvl_cur - r_tok;
                r_slot_vld[r_sidx] <= 1'b1;
                r_uent_vld[r_uaddr] <= 1'b1;
            end
            // slot release
            if (r_state == ST_FREE_WR) begin
                r_level[r_bidx]    <= free_lvl;
                r_slot_vld[r_sidx] <= 1'b0;
                r_uent_vld[r_uaddr] <= 1'b1;
            end
            // output register
            if (res_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // usage memory
    always_ff @(posedge i_clk) begin
        r_udata <= r_umem[r_uaddr];
        r_uvld  <= r_uent_vld[r_uaddr];
        if (r_state == ST_REQ_DONE && !no_tokens && r_found) begin
            r_umem[r_uaddr] <= grant_usage;
        end
        if (r_state == ST_FREE_WR) begin
            r_umem[r_uaddr] <= free_usage;
        end
    end

    // sequencer payload and result staging
    always_ff @(posedge i_clk) begin
        if (r_state == ST_REQ_DONE && !no_tokens && r_found) begin
            r_slot[r_sidx] <= '{agent: r_a, bucket: r_b, tokens: r_tok,
                                expiry: r_now + {8'd0, r_hold}};
        end
        if (res_load) begin
            r_o_st  <= r_st;
            r_o_gh  <= r_gh;
            r_o_tg  <= r_tg;
            r_o_av  <= r_av;
            r_o_us  <= r_us;
            r_o_exp <= r_exp;
        end
        unique case (r_state)
            ST_IDLE: begin
                r_op    <= t_op'(i_opcode);
                r_now   <= i_now_time;
                r_b     <= i_bucket_index;
                r_a     <= i_agent_index;
                r_tok   <= i_token_count;
                r_hold  <= i_hold_time;
                r_h     <= i_handle;
                r_bidx  <= i_bucket_index;
                r_uaddr <= {i_agent_index, i_bucket_index};
                r_sidx  <= '0;
                r_exp   <= '0;
                r_st    <= STS_OK;
                r_gh    <= '0;
                r_tg    <= '0;
                r_av    <= '0;
                r_us    <= '0;
            end
            ST_DISPATCH: begin
                if (r_op == OP_REFILL_ALL) r_bidx <= '0;
                if (r_op == OP_RELEASE) begin
                    r_sidx <= r_h;
                    r_st   <= r_slot_vld[r_h] ? STS_OK : STS_BAD_HANDLE;
                end
            end
            ST_REQ_QCHK: begin
                r_usage <= u_cur;
                r_st    <= STS_QUOTA;
                r_av    <= lvl_cur;
                r_us    <= u_cur;
            end
            ST_RF_MUL: r_prod <= div_quo * {16'd0, r_rate};
            ST_RF_NEXT: begin
                if (r_op == OP_REQUEST) begin
                    r_sidx <= '0;
                end else if (r_bidx != BUCKET_LAST) begin
                    r_bidx <= r_bidx + 1'b1;
                end
            end
            ST_REQ_SCAN: begin
                r_found <= !r_slot_vld[r_sidx];
                if (r_slot_vld[r_sidx] && r_sidx != SLOT_LAST) r_sidx <= r_sidx + 1'b1;
            end
            ST_REQ_DONE: begin
                r_av <= lvl_cur;
                r_us <= r_usage;
                if (no_tokens) begin
                    r_st <= STS_NO_TOKENS;
                end else if (!r_found) begin
                    r_st <= STS_TABLE_FULL;
                end else begin
                    r_st <= STS_OK;
                    r_gh <= 5'(r_sidx);
                    r_tg <= r_tok;
                    r_av <= lvl_cur - r_tok;
                    r_us <= grant_usage;
                end
            end
            ST_FREE_RD: begin
                r_bidx  <= slot_cur.bucket;
                r_uaddr <= {slot_cur.agent, slot_cur.bucket};
            end
            ST_FREE_WR: begin
                r_av <= free_lvl;
                r_us <= free_usage;
                if (r_op == OP_EXPIRE && r_sidx != SLOT_LAST) r_sidx <= r_sidx + 1'b1;
            end
            ST_SW_CHK: begin
                if (expired) begin
                    r_exp <= r_exp + 6'd1;
                end else if (r_sidx != SLOT_LAST) begin
                    r_sidx <= r_sidx + 1'b1;
                end
            end
            ST_FIN_RD: begin
                r_bidx  <= r_b;
                r_uaddr <= {r_a, r_b};
            end
            ST_FIN_OUT: begin
                r_av <= lvl_cur;
                r_us <= u_cur;
            end
            default: ;
        endcase
    end

    assign o_stall            = (r_state != ST_IDLE);
    assign o_valid            = r_ovalid;
    assign o_status           = r_o_st;
    assign o_granted_handle   = r_o_gh;
    assign o_tokens_granted   = r_o_tg;
    assign o_tokens_available = r_o_av;
    assign o_agent_usage_now  = r_o_us;
    assign o_expired_count    = r_o_exp;

`ifndef NO_ASSERTIONS
    // a grant marks its slot as held
    a_grant_sets_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REQ_DONE && !no_tokens && r_found) |=> r_slot_vld[$past(r_sidx)])
        else $error("granted slot not marked valid");

    // a refused request never reports granted tokens
    a_refused_no_tokens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != STS_OK) |-> (o_tokens_granted == 16'd0))
        else $error("tokens reported on a refused beat");

    // the sweep never counts more slots than exist
    a_expired_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_expired_count <= 6'(SLOTS)))
        else $error("expired count beyond table size");

    // the divider only runs inside a refill
    a_div_in_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_RF_DIV))
        else $error("divider finished outside a refill");
`endif

endmodule
